>>> hw/rtl/lplct_pkg.sv
// Package for the line position and lane change tracker.
// Shared widths, register indexes, reset values and row helper functions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lplct_pkg;

  localparam int NUM_SENSORS   = 9;
  localparam int SAMPLE_W      = 10;
  localparam int HISTORY_DEPTH = 8;
  localparam int PTR_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W         = 4;

  localparam int IN_TDATA_W  = ((NUM_SENSORS * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  // steering codes
  localparam logic [IDX_W-1:0] CENTRE     = 4'd4;
  localparam logic [IDX_W-1:0] LEFT_PICK  = 4'd8;
  localparam logic [IDX_W-1:0] RIGHT_PICK = 4'd0;
  localparam logic [IDX_W-1:0] RIGHT_TURN = 4'd1;

  // row consulted when a split run reaches the end of the history
  localparam int FALLBACK_ROW = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_THRESHOLD = 3'd0,
    REG_TURN_LIMIT     = 3'd1,
    REG_SPLIT_RUN      = 3'd2,
    REG_STOP_WINDOW    = 3'd3,
    REG_START_COUNT    = 3'd4
  } cfg_reg_t;

  localparam logic [9:0] RST_LINE_THRESHOLD = 10'd650;
  localparam logic [6:0] RST_TURN_LIMIT     = 7'd90;
  localparam logic [3:0] RST_SPLIT_RUN      = 4'd3;
  localparam logic [3:0] RST_STOP_WINDOW    = 4'd3;
  localparam logic [3:0] RST_START_COUNT    = 4'd5;

  typedef logic [NUM_SENSORS-1:0] row_t;

  // result word, steer index in the low bits
  typedef struct packed {
    logic             lane_change_active;
    logic             stop_flag;
    logic             start_flag;
    logic [IDX_W-1:0] steer_index;
  } result_t;

  function automatic logic [IDX_W-1:0] low_bit(input row_t row);
    logic [IDX_W-1:0] r;
    r = CENTRE;
    for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
      if (row[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] high_bit(input row_t row);
    logic [IDX_W-1:0] r;
    r = CENTRE;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (row[i]) r = IDX_W'(i);
    end
    return r;
  endfunction

  // gap inside the lit span, span wider than two
  function automatic logic is_split(input row_t row);
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic             gap;
    lo  = low_bit(row);
    hi  = high_bit(row);
    gap = 1'b0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if ((IDX_W'(i) >= lo) && (IDX_W'(i) < hi) && !row[i]) gap = 1'b1;
    end
    if ({1'b0, hi} <= ({1'b0, lo} + 5'd1)) gap = 1'b0;
    return gap;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/line_position_lane_change_tracker.sv
// Line position and lane change tracker, top level.
// Depends on lplct_pkg. History rows live in a circular RAM read one row a cycle.
//
//  channel | dir | handshake          | word contents (low bit up)
//  --------+-----+--------------------+----------------------------------------
//  in_     | in  | tvalid/tready      | sample_0..sample_8, 10 b each, 6 b pad
//  out_    | out | tvalid/tready      | steer_index 4b, start, stop, lane, pad
//  cfg_    | in  | cfg_we, no wait    | cfg_index selects register, cfg_wdata
//
// Steps: a word with a lit vector is accepted, then finished. A blank
// vector first sweeps all HISTORY_DEPTH rows through the registered read
// port of the history RAM, then finishes.
// One word in flight; the next is taken as soon as the finish cycle is done,
// even while the previous result still waits in the output register.
// Finish holds while the output register is full and not taken.
// Reset (rst_n low, synchronous) clears control, pointer and row valid bits;
// unwritten RAM rows read as zero. Registers return to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module line_position_lane_change_tracker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // sample_0 [9:0], sample_1 [19:10], ... sample_8 [89:80], zero pad
  input  logic [lplct_pkg::IN_TDATA_W-1:0]    in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // steer_index [3:0], start_flag [4], stop_flag [5], lane_change_active [6]
  output logic [lplct_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                                cfg_we,
  input  logic [lplct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lplct_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  import lplct_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FIN} state_t;

  state_t state_r;

  // configuration
  logic [9:0] line_threshold_r;
  logic [6:0] turn_limit_r;
  logic [3:0] split_run_r;
  logic [3:0] stop_window_r;
  logic [3:0] start_count_r;

  // tracker state
  logic             pend_r;
  logic             go_left_r;
  logic             go_right_r;
  logic [IDX_W-1:0] held_r;
  logic [6:0]       turn_r;
  logic [PTR_W-1:0] head_r;

  // current word
  row_t v_r;
  logic start_r;
  logic stop_r;

  // sweep
  logic [CNT_W-1:0] rd_cnt_r;
  logic             rvalid_r;
  logic [PTR_W-1:0] ri_r;
  logic [CNT_W-1:0] run_r;
  logic             found_r;
  logic             last_found_r;
  logic             left_r;
  logic [IDX_W-1:0] prev_hi_r;
  logic [IDX_W-1:0] hi3_r;
  logic [IDX_W-1:0] hi4_r;
  logic [IDX_W-1:0] lowbit0_r;

  // history RAM
  row_t                     hist_mem [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hist_vld_r;
  row_t                     rd_row_r;
  logic                     rd_vld_r;

  // output register
  logic    out_tvalid_r;
  result_t out_res_r;

  // ---------------- thresholding of the incoming word ----------------
  row_t       v_in;
  logic [3:0] lit;

  always_comb begin
    v_in = '0;
    lit  = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      if (in_tdata[i*SAMPLE_W +: SAMPLE_W] > line_threshold_r) begin
        v_in[i] = 1'b1;
        lit     = lit + 4'd1;
      end
    end
  end

  // ---------------- RAM addressing ----------------
  logic [PTR_W-1:0] rd_idx;
  logic [PTR_W-1:0] rd_addr;
  logic             rd_en;
  logic [PTR_W-1:0] head_inc;

  assign rd_idx  = rd_cnt_r[PTR_W-1:0];
  assign rd_en   = (state_r == S_SCAN) && (rd_cnt_r < CNT_W'(HISTORY_DEPTH));
  // row k sits k places behind the head
  assign rd_addr = (head_r >= rd_idx) ? (head_r - rd_idx)
                 : PTR_W'({1'b0, head_r} + (PTR_W+1)'(HISTORY_DEPTH) - {1'b0, rd_idx});
  assign head_inc = (head_r == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);

  // ---------------- per-row sweep logic ----------------
  row_t             row_cur;
  logic             row_split;
  logic [IDX_W-1:0] row_hi;
  logic [CNT_W-1:0] run_inc;
  logic [3:0]       need;

  assign row_cur   = rd_vld_r ? rd_row_r : '0;
  assign row_split = is_split(row_cur);
  assign row_hi    = high_bit(row_cur);
  assign run_inc   = row_split ? run_r + CNT_W'(1) : '0;
  assign need      = (split_run_r == 4'd0) ? 4'd1 : split_run_r;

  // ---------------- finish decision ----------------
  logic             fin_fire;
  logic             blank;
  logic             take_left;
  logic             push_en;
  row_t             push_row;
  logic [IDX_W-1:0] steer;
  logic             pend_nxt;
  logic             go_left_nxt;
  logic             go_right_nxt;
  logic [IDX_W-1:0] held_nxt;
  logic [6:0]       turn_nxt;

  assign fin_fire  = (state_r == S_FIN) && (!out_tvalid_r || out_tready);
  assign blank     = (v_r == '0);
  // run ran off the end: compare the fallback row with the one before it
  assign take_left = last_found_r ? left_r : (hi4_r < hi3_r);

  always_comb begin
    push_en      = 1'b0;
    push_row     = v_r;
    steer        = low_bit(v_r);
    pend_nxt     = pend_r;
    go_left_nxt  = go_left_r;
    go_right_nxt = go_right_r;
    held_nxt     = held_r;
    turn_nxt     = turn_r;
    if (pend_r) begin
      if (blank) begin
        pend_nxt = 1'b0;
        push_en  = 1'b1;
        push_row = row_t'(1) << CENTRE;
        steer    = CENTRE;
      end else begin
        steer = held_r;
      end
    end else if ((go_left_r || go_right_r) && blank) begin
      if (turn_r < turn_limit_r) begin
        turn_nxt = turn_r + 7'd1;
        steer    = go_left_r ? LEFT_PICK : RIGHT_TURN;
        push_en  = 1'b1;
        push_row = row_t'(1) << steer;
      end else begin
        steer = CENTRE;
      end
    end else begin
      if (go_left_r || go_right_r) begin
        turn_nxt     = '0;
        go_left_nxt  = 1'b0;
        go_right_nxt = 1'b0;
      end
      if (blank) begin
        if (found_r) begin
          steer        = take_left ? LEFT_PICK : RIGHT_PICK;
          pend_nxt     = 1'b1;
          go_left_nxt  = take_left;
          go_right_nxt = !take_left;
          held_nxt     = steer;
          push_en      = 1'b1;
          push_row     = row_t'(1) << steer;
        end else begin
          steer = lowbit0_r;
        end
      end else begin
        push_en = 1'b1;
      end
    end
  end

  // ---------------- history RAM ----------------
  always_ff @(posedge clk) begin
    if (fin_fire && push_en) hist_mem[head_inc] <= push_row;
    if (rd_en) rd_row_r <= hist_mem[rd_addr];
  end

  // ---------------- control and registered outputs ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      line_threshold_r <= RST_LINE_THRESHOLD;
      turn_limit_r     <= RST_TURN_LIMIT;
      split_run_r      <= RST_SPLIT_RUN;
      stop_window_r    <= RST_STOP_WINDOW;
      start_count_r    <= RST_START_COUNT;
      pend_r           <= 1'b0;
      go_left_r        <= 1'b0;
      go_right_r       <= 1'b0;
      held_r           <= '0;
      turn_r           <= '0;
      head_r           <= '0;
      hist_vld_r       <= '0;
      rvalid_r         <= 1'b0;
      out_tvalid_r     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_THRESHOLD: line_threshold_r <= cfg_wdata;
          REG_TURN_LIMIT:     turn_limit_r     <= cfg_wdata[6:0];
          REG_SPLIT_RUN:      split_run_r      <= cfg_wdata[3:0];
          REG_STOP_WINDOW:    stop_window_r    <= cfg_wdata[3:0];
          REG_START_COUNT:    start_count_r    <= cfg_wdata[3:0];
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready) out_tvalid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            v_r          <= v_in;
            start_r      <= (lit >= start_count_r);
            stop_r       <= 1'b0;
            found_r      <= 1'b0;
            last_found_r <= 1'b0;
            run_r        <= '0;
            rd_cnt_r     <= '0;
            rvalid_r     <= 1'b0;
            state_r      <= (v_in == '0) ? S_SCAN : S_FIN;
          end
        end
        S_SCAN: begin
          rvalid_r <= rd_en;
          if (rd_en) begin
            ri_r     <= rd_idx;
            rd_cnt_r <= rd_cnt_r + CNT_W'(1);
          end
          rd_vld_r <= hist_vld_r[rd_addr];
          if (rvalid_r) begin
            if ({4'b0, ri_r} < {PTR_W'(0), stop_window_r} && (row_cur == '1))
              stop_r <= 1'b1;
            if (ri_r == '0) lowbit0_r <= low_bit(row_cur);
            if (ri_r == PTR_W'(FALLBACK_ROW - 1)) hi3_r <= row_hi;
            if (ri_r == PTR_W'(FALLBACK_ROW)) hi4_r <= row_hi;
            if (!found_r) begin
              run_r <= run_inc;
              if ({4'b0, run_inc} >= {CNT_W'(0), need}) found_r <= 1'b1;
            end else if (!last_found_r && !row_split) begin
              // first plain row above the split run
              last_found_r <= 1'b1;
              left_r       <= (row_hi < prev_hi_r);
            end
            prev_hi_r <= row_hi;
            if (ri_r == PTR_W'(HISTORY_DEPTH - 1)) state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_fire) begin
            pend_r       <= pend_nxt;
            go_left_r    <= go_left_nxt;
            go_right_r   <= go_right_nxt;
            held_r       <= held_nxt;
            turn_r       <= turn_nxt;
            if (push_en) begin
              head_r               <= head_inc;
              hist_vld_r[head_inc] <= 1'b1;
            end
            out_tvalid_r                 <= 1'b1;
            out_res_r.steer_index        <= steer;
            out_res_r.start_flag         <= start_r;
            out_res_r.stop_flag          <= stop_r;
            out_res_r.lane_change_active <= pend_nxt;
            state_r                      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res_r};

endmodule

`default_nettype wire

>>> hw/rtl/lplct_checker.sv
// Port-level checker for the line position and lane change tracker.
// Depends on lplct_pkg; bound to the top level at the end of this file.
`timescale 1ns / 1ps
`default_nettype none

module lplct_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic [lplct_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [lplct_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic                              cfg_we,
  input wire logic [lplct_pkg::CFG_IDX_W-1:0]   cfg_index,
  input wire logic [lplct_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  import lplct_pkg::*;

  // a held result word does not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // no output straight after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // one word in flight: the cycle after an accept takes nothing new
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // while a lane change is pending the steer index points to a side
  a_lane_side: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[6] |->
      (out_tdata[3:0] == LEFT_PICK) || (out_tdata[3:0] == RIGHT_PICK))
    else $error("pending lane change without side index");

  // steer index stays within the sensor row
  a_steer_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[3:0] <= IDX_W'(NUM_SENSORS - 1))
    else $error("steer index out of range");

  logic unused_ok;
  assign unused_ok = ^{in_tdata, cfg_we, cfg_index, cfg_wdata};

endmodule

bind line_position_lane_change_tracker lplct_checker u_lplct_checker (.*);

`default_nettype wire
